/* design/spf_pkg.sv */
// Shared constants, types and the CORDIC arctangent table of the solar position pipeline.
// Used by every module of the block; depends on nothing.
package spf_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 30;
   localparam int ATAN_COUNT           = 30;

   localparam int MEAN_LAT = 4;
   localparam int FOLD_LAT = 2;
   localparam int COMB_LAT = 4;

   localparam int DAY_W  = 32;
   localparam int DEG_W  = 25;
   localparam int RAW_W  = 27;
   localparam int FOLD_W = 23;
   localparam int ANG_W  = 31;
   localparam int XW     = 33;
   localparam int DIST_W = 17;

   localparam logic [RAW_W-1:0] FIX_CIRCLE  = RAW_W'(360 * 65536);
   localparam logic [RAW_W-1:0] FIX_HALF    = RAW_W'(180 * 65536);
   localparam logic [RAW_W-1:0] FIX_QUARTER = RAW_W'(90 * 65536);

   localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);
   localparam logic [24:0] DEG_TO_Q30 = 25'd18740330;

   typedef struct packed {
      logic                 neg;
      logic signed [XW-1:0] y;
   } lane_out_type;

   function automatic logic [31:0] cordic_atan(input int unsigned i);
      logic [31:0] v;
      case (i)
         0:  v = 32'd843314857;
         1:  v = 32'd497837829;
         2:  v = 32'd263043837;
         3:  v = 32'd133525159;
         4:  v = 32'd67021687;
         5:  v = 32'd33543516;
         6:  v = 32'd16775851;
         7:  v = 32'd8388437;
         8:  v = 32'd4194283;
         9:  v = 32'd2097149;
         10: v = 32'd1048575;
         11: v = 32'd524288;
         12: v = 32'd262144;
         13: v = 32'd131072;
         14: v = 32'd65536;
         15: v = 32'd32768;
         16: v = 32'd16384;
         17: v = 32'd8192;
         18: v = 32'd4096;
         19: v = 32'd2048;
         20: v = 32'd1024;
         21: v = 32'd512;
         22: v = 32'd256;
         23: v = 32'd128;
         24: v = 32'd64;
         25: v = 32'd32;
         26: v = 32'd16;
         27: v = 32'd8;
         28: v = 32'd4;
         29: v = 32'd2;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

/* design/spf_mean.sv */
// Mean longitude and mean anomaly: linear in the day count, reduced modulo 360 degrees.
// Four register stages; depends on spf_pkg.
module spf_mean (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [spf_pkg::DAY_W-1:0]  day,
   output logic [spf_pkg::DEG_W-1:0]         mean_lon,
   output logic [spf_pkg::DEG_W-1:0]         mean_anom
);

   // Lane 0 is the mean longitude, lane 1 the mean anomaly.
   localparam logic signed [17:0] RATE [2] = '{18'sd64595, 18'sd64592};
   localparam logic signed [33:0] BASE [2] = '{34'sd18380650, 34'sd23431028};

   logic [spf_pkg::DEG_W-1:0] res [2];

   for (genvar k = 0; k < 2; k++) begin : g_lane
      logic signed [49:0] prod_ff;
      logic signed [49:0] prod_in;
      logic signed [33:0] sum_ff;
      logic signed [33:0] sum_in;
      logic [15:0]        qp_ff;
      logic [15:0]        qp_in;
      logic [10:0]        qq_ff;
      logic [10:0]        qq_in;
      logic [18:0]        r_ff;
      logic [18:0]        r_in;
      logic [24:0]        out_ff;
      logic [24:0]        out_in;
      logic [31:0]        recip;
      logic [15:0]        rem;
      logic [15:0]        fix;

      always_comb begin
         prod_in = day * RATE[k];
         sum_in  = $signed(prod_ff[49:16]) + BASE[k];
         // Offset by a multiple of 45 so the quotient from bit 19 up is positive.
         qp_in   = {sum_ff[33], sum_ff[33:19]} + 16'd16425;
         r_in    = sum_ff[18:0];
         recip   = 32'(qp_in) * 32'd46603;
         qq_in   = recip[31:21];
         rem     = qp_ff - 16'(qq_ff) * 16'd45;
         fix     = (rem >= 16'd45) ? rem - 16'd45 : rem;
         out_in  = {fix[5:0], r_ff};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            prod_ff <= prod_in;
            sum_ff  <= sum_in;
            qp_ff   <= qp_in;
            qq_ff   <= qq_in;
            r_ff    <= r_in;
            out_ff  <= out_in;
         end
      end

      assign res[k] = out_ff;
   end

   assign mean_lon  = res[0];
   assign mean_anom = res[1];

endmodule

/* design/spf_fold.sv */
// Angle preparation for one sine lane: wrap to a circle, fold to the first quadrant, convert to Q30.
// Two register stages; depends on spf_pkg.
module spf_fold (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [spf_pkg::RAW_W-1:0]    deg_raw,
   output logic [spf_pkg::ANG_W-1:0]    ang,
   output logic                         neg
);

   logic [spf_pkg::RAW_W-1:0]  wrapped;
   logic [spf_pkg::RAW_W-1:0]  half_off;
   logic [spf_pkg::RAW_W-1:0]  folded;
   logic                       neg_in;
   logic                       neg_a_ff;
   logic                       neg_b_ff;
   logic [spf_pkg::FOLD_W-1:0] deg_ff;
   logic [spf_pkg::FOLD_W-1:0] deg_in;
   logic [47:0]                prod;
   logic [spf_pkg::ANG_W-1:0]  ang_ff;
   logic [spf_pkg::ANG_W-1:0]  ang_in;

   always_comb begin
      if (deg_raw >= (spf_pkg::FIX_CIRCLE << 1)) begin
         wrapped = deg_raw - (spf_pkg::FIX_CIRCLE << 1);
      end else if (deg_raw >= spf_pkg::FIX_CIRCLE) begin
         wrapped = deg_raw - spf_pkg::FIX_CIRCLE;
      end else begin
         wrapped = deg_raw;
      end
      neg_in   = wrapped > spf_pkg::FIX_HALF;
      half_off = neg_in ? wrapped - spf_pkg::FIX_HALF : wrapped;
      folded   = (half_off > spf_pkg::FIX_QUARTER) ? spf_pkg::FIX_HALF - half_off : half_off;
      deg_in   = folded[spf_pkg::FOLD_W-1:0];
      prod     = 48'(deg_ff) * 48'(spf_pkg::DEG_TO_Q30);
      ang_in   = prod[46:16];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         deg_ff   <= deg_in;
         neg_a_ff <= neg_in;
         ang_ff   <= ang_in;
         neg_b_ff <= neg_a_ff;
      end
   end

   assign ang = ang_ff;
   assign neg = neg_b_ff;

endmodule

/* design/spf_cordic.sv */
// Pipelined rotation CORDIC for one sine lane, one register stage per step, in Q30.
// Depends on spf_pkg for the gain start value and the arctangent table.
module spf_cordic #(
   parameter int CORDIC_STEPS = spf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [spf_pkg::ANG_W-1:0]   ang,
   input  logic                        neg,
   output spf_pkg::lane_out_type       result
);

   localparam int XW = spf_pkg::XW;

   logic signed [XW-1:0] x_ff   [CORDIC_STEPS];
   logic signed [XW-1:0] y_ff   [CORDIC_STEPS];
   logic signed [XW-1:0] z_ff   [CORDIC_STEPS];
   logic                 neg_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [XW-1:0] xp;
      logic signed [XW-1:0] yp;
      logic signed [XW-1:0] zp;
      logic                 np;
      logic signed [XW-1:0] atan_v;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [XW-1:0] z_in;

      if (i == 0) begin : g_first
         assign xp = spf_pkg::CORDIC_X0;
         assign yp = '0;
         assign zp = $signed({2'b00, ang});
         assign np = neg;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign np = neg_ff[i-1];
      end

      assign atan_v = $signed({1'b0, spf_pkg::cordic_atan(i)});

      always_comb begin
         if (!zp[XW-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - atan_v;
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + atan_v;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            neg_ff[i] <= np;
         end
      end
   end

   assign result.neg = neg_ff[CORDIC_STEPS-1];
   assign result.y   = y_ff[CORDIC_STEPS-1];

endmodule

/* design/spf_combine.sv */
// Harmonic sums: applies sine signs, scales by the series coefficients, adds and wraps.
// Four register stages, the last one being the output register; depends on spf_pkg.
module spf_combine (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [spf_pkg::DEG_W-1:0]     mean_lon,
   input  spf_pkg::lane_out_type         lane [5],
   output logic [spf_pkg::DEG_W-1:0]     sun_longitude,
   output logic [spf_pkg::DIST_W-1:0]    sun_distance
);

   // Lanes: sin g, sin 2g, sin 3g, cos g, cos 2g.
   localparam logic signed [17:0] COEF [5] =
      '{18'sd125475, 18'sd1310, 18'sd19, 18'sd1095, 18'sd9};

   logic signed [18:0] s_ff [5];
   logic signed [36:0] p_ff [5];
   logic signed [20:0] t    [5];
   logic [spf_pkg::DEG_W-1:0] l1_ff;
   logic [spf_pkg::DEG_W-1:0] l2_ff;
   logic signed [26:0] lon_ff;
   logic signed [26:0] lon_in;
   logic signed [17:0] dist_ff;
   logic signed [17:0] dist_in;
   logic [spf_pkg::DEG_W-1:0]  lon_out_ff;
   logic [spf_pkg::DEG_W-1:0]  lon_out_in;
   logic [spf_pkg::DIST_W-1:0] dist_out_ff;

   for (genvar k = 0; k < 5; k++) begin : g_term
      logic signed [spf_pkg::XW-1:0] ys;
      assign ys = lane[k].neg ? -lane[k].y : lane[k].y;
      assign t[k] = p_ff[k][36:16];
      always_ff @(posedge clock) begin
         if (advance) begin
            s_ff[k] <= ys[spf_pkg::XW-1:14];
            p_ff[k] <= s_ff[k] * COEF[k];
         end
      end
   end

   always_comb begin
      lon_in = $signed({2'b00, l2_ff}) + 27'(t[0]) + 27'(t[1]) + 27'(t[2]);
      dist_in = 18'sd65545 - 18'(t[3]) - 18'(t[4]);
      if (lon_ff[26]) begin
         lon_out_in = spf_pkg::DEG_W'(lon_ff + $signed({1'b0, spf_pkg::FIX_CIRCLE}));
      end else if (lon_ff >= $signed({1'b0, spf_pkg::FIX_CIRCLE})) begin
         lon_out_in = spf_pkg::DEG_W'(lon_ff - $signed({1'b0, spf_pkg::FIX_CIRCLE}));
      end else begin
         lon_out_in = lon_ff[spf_pkg::DEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_ff       <= mean_lon;
         l2_ff       <= l1_ff;
         lon_ff      <= lon_in;
         dist_ff     <= dist_in;
         lon_out_ff  <= lon_out_in;
         dist_out_ff <= dist_ff[spf_pkg::DIST_W-1:0];
      end
   end

   assign sun_longitude = lon_out_ff;
   assign sun_distance  = dist_out_ff;

endmodule

/* design/solar_position_fixed_point_top.sv */
// Solar position pipeline top level: mean elements, five CORDIC sine lanes, harmonic sums.
// Depends on spf_pkg, spf_mean, spf_fold, spf_cordic and spf_combine.
//
// Usage: each beat on the req_ channel carries one signed Q16.16 day count since J2000.
// Each accepted beat yields exactly one beat on the rsp_ channel with the Sun's ecliptic
// longitude (degrees, Q9.16, 0 to 360) and its distance (AU, Q1.16), in input order.
// Each beat passes in order through the mean elements and their modulo-360 reduction, the
// quadrant folding and the conversion to Q30 radians, the CORDIC steps, and the harmonic
// sums and the final wrap.
// Throughput is one beat per cycle while the pipeline is not stalled; the five sine and cosine
// terms each have their own CORDIC lane so no unit is shared between terms.
// The whole pipeline advances as one: it moves whenever the output register is empty or
// is being taken. When the receiver holds rsp_tready low with a result waiting, every stage
// holds and req_tready drops in the same cycle, so nothing is lost or repeated.
// Reset clears all stage valid bits; data registers are not reset and the block accepts a
// beat in the first cycle after reset is released.
module solar_position_fixed_point_top #(
   parameter int CORDIC_STEPS = spf_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] day_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [24:0] sun_longitude, [41:25] sun_distance, zero fill
);

   localparam int LAT = spf_pkg::MEAN_LAT + spf_pkg::FOLD_LAT + CORDIC_STEPS
                        + spf_pkg::COMB_LAT;
   localparam int DLY = spf_pkg::FOLD_LAT + CORDIC_STEPS;
   localparam int RW  = spf_pkg::RAW_W;

   logic                        advance;
   logic [LAT-1:0]              valid_ff;
   logic [LAT-1:0]              valid_in;
   logic [spf_pkg::DEG_W-1:0]   mean_lon;
   logic [spf_pkg::DEG_W-1:0]   mean_anom;
   logic [RW-1:0]               g1;
   logic [RW-1:0]               g2;
   logic [RW-1:0]               raw [5];
   logic [spf_pkg::ANG_W-1:0]   ang [5];
   logic                        neg [5];
   spf_pkg::lane_out_type       lane [5];
   logic [spf_pkg::DEG_W-1:0]   lon_dly_ff [DLY];
   logic [spf_pkg::DEG_W-1:0]   sun_longitude;
   logic [spf_pkg::DIST_W-1:0]  sun_distance;

   // The pipeline moves as a unit whenever the output slot is free or being emptied.
   assign advance    = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   spf_mean u_mean (
      .clock     (clock),
      .advance   (advance),
      .day       ($signed(req_tdata)),
      .mean_lon  (mean_lon),
      .mean_anom (mean_anom)
   );

   // Angles fed to the sine lanes: g, 2g, 3g, and the cosines as g + 90 and 2g + 90.
   assign g1     = RW'(mean_anom);
   assign g2     = g1 << 1;
   assign raw[0] = g1;
   assign raw[1] = g2;
   assign raw[2] = g1 + g2;
   assign raw[3] = g1 + spf_pkg::FIX_QUARTER;
   assign raw[4] = g2 + spf_pkg::FIX_QUARTER;

   for (genvar k = 0; k < 5; k++) begin : g_lane
      spf_fold u_fold (
         .clock   (clock),
         .advance (advance),
         .deg_raw (raw[k]),
         .ang     (ang[k]),
         .neg     (neg[k])
      );

      spf_cordic #(
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_cordic (
         .clock   (clock),
         .advance (advance),
         .ang     (ang[k]),
         .neg     (neg[k]),
         .result  (lane[k])
      );
   end

   // The mean longitude waits alongside the sine lanes.
   for (genvar j = 0; j < DLY; j++) begin : g_dly
      always_ff @(posedge clock) begin
         if (advance) begin
            lon_dly_ff[j] <= (j == 0) ? mean_lon : lon_dly_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   spf_combine u_combine (
      .clock         (clock),
      .advance       (advance),
      .mean_lon      (lon_dly_ff[DLY-1]),
      .lane          (lane),
      .sun_longitude (sun_longitude),
      .sun_distance  (sun_distance)
   );

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {6'd0, sun_distance, sun_longitude};

   // A stalled pipeline keeps every item in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline valid bits moved during a stall");

   // A delivered longitude is always reduced into one circle.
   a_lon_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:0] < 25'(360 * 65536)))
      else $error("longitude outside one circle");

   // The distance series stays close to one astronomical unit.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[41:25] >= 17'd64000 && rsp_tdata[41:25] <= 17'd67100))
      else $error("distance outside expected range");

   // An accepted beat always shows up in the first stage on the next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted beat did not enter the pipeline");

endmodule
